>>> rtl/spd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Sorted priority deque package
// Shared constants, operation codes and controller/datapath interface types.
// ============================================================================
package spd_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_W    = $clog2(CAPACITY + 1);
    localparam int COUNT_W  = 5;
    localparam int VALUE_W  = 32;
    localparam int PRI_W    = 8;

    typedef enum logic [1:0] {
        FUNC_INSERT     = 2'd0,
        FUNC_POP_FRONT  = 2'd1,
        FUNC_PUSH_FRONT = 2'd2,
        FUNC_POP_REAR   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        OP_INSERT,
        OP_PUSH_FRONT,
        OP_POP_FRONT,
        OP_POP_REAR,
        OP_REJECT_FULL,
        OP_REJECT_EMPTY
    } op_t;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic exec;
        op_t  op;
    } cmd_t;

    // Store status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
    } stat_t;

endpackage

>>> rtl/spd_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// Sorted priority deque datapath
// Row of sorted cells with per-cell compare and shift, occupancy counter and
// the result register.
// ============================================================================
module spd_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  spd_pkg::cmd_t                       cmd,
    input  logic signed [spd_pkg::VALUE_W-1:0]  value,
    input  logic        [spd_pkg::PRI_W-1:0]    priority_req,
    output spd_pkg::stat_t                      stat,
    output logic signed [spd_pkg::VALUE_W-1:0]  value_res,
    output logic        [1:0]                   status,
    output logic        [spd_pkg::COUNT_W-1:0]  count
);

    logic [spd_pkg::OCC_W-1:0]   occ_reg;
    logic [spd_pkg::OCC_W-1:0]   occ_next;
    logic [spd_pkg::OCC_W-1:0]   last_pos;
    logic [spd_pkg::VALUE_W-1:0] val_reg [spd_pkg::CAPACITY];
    logic [spd_pkg::PRI_W-1:0]   pri_reg [spd_pkg::CAPACITY];
    logic [spd_pkg::CAPACITY-1:0] le;

    logic signed [spd_pkg::VALUE_W-1:0] value_res_reg;
    logic signed [spd_pkg::VALUE_W-1:0] value_res_next;
    spd_pkg::status_t                   status_reg;
    spd_pkg::status_t                   status_next;

    assign stat.empty = (occ_reg == '0);
    assign stat.full  = (occ_reg == spd_pkg::OCC_W'(spd_pkg::CAPACITY));
    assign last_pos   = occ_reg - spd_pkg::OCC_W'(1);

    // Each cell flags whether it holds a live entry that stays ahead of the
    // incoming priority; the flags form a run of ones from the head.
    genvar gi;
    generate
        for (gi = 0; gi < spd_pkg::CAPACITY; gi++) begin : g_cmp
            assign le[gi] = (spd_pkg::OCC_W'(gi) < occ_reg) && (pri_reg[gi] <= priority_req);
        end
    endgenerate

    always_comb
    begin
        occ_next       = occ_reg;
        value_res_next = '0;
        status_next    = spd_pkg::STATUS_OK;
        unique case (cmd.op)
            spd_pkg::OP_INSERT, spd_pkg::OP_PUSH_FRONT:
            begin
                occ_next = occ_reg + spd_pkg::OCC_W'(1);
            end
            spd_pkg::OP_POP_FRONT:
            begin
                occ_next       = occ_reg - spd_pkg::OCC_W'(1);
                value_res_next = val_reg[0];
            end
            spd_pkg::OP_POP_REAR:
            begin
                occ_next       = occ_reg - spd_pkg::OCC_W'(1);
                value_res_next = val_reg[last_pos[spd_pkg::IDX_W-1:0]];
            end
            spd_pkg::OP_REJECT_FULL:
            begin
                status_next = spd_pkg::STATUS_FULL;
            end
            spd_pkg::OP_REJECT_EMPTY:
            begin
                status_next = spd_pkg::STATUS_EMPTY;
            end
            default:
            begin
                occ_next = occ_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (cmd.exec)
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            value_res_reg <= value_res_next;
            status_reg    <= status_next;
        end
    end

    // Cell update: keep, take the new entry, or take a neighbor's entry.
    generate
        for (gi = 0; gi < spd_pkg::CAPACITY; gi++) begin : g_cell
            logic prev_le;
            logic [spd_pkg::VALUE_W-1:0] up_val;
            logic [spd_pkg::PRI_W-1:0]   up_pri;
            logic [spd_pkg::VALUE_W-1:0] dn_val;
            logic [spd_pkg::PRI_W-1:0]   dn_pri;

            if (gi == 0) begin : g_head
                assign prev_le = 1'b1;
                assign up_val  = value;
                assign up_pri  = priority_req;
            end
            else begin : g_body
                assign prev_le = le[gi-1];
                assign up_val  = val_reg[gi-1];
                assign up_pri  = pri_reg[gi-1];
            end

            if (gi == spd_pkg::CAPACITY - 1) begin : g_tail
                assign dn_val = val_reg[gi];
                assign dn_pri = pri_reg[gi];
            end
            else begin : g_inner
                assign dn_val = val_reg[gi+1];
                assign dn_pri = pri_reg[gi+1];
            end

            always_ff @(posedge clk)
            begin
                if (cmd.exec)
                begin
                    case (cmd.op)
                        spd_pkg::OP_INSERT:
                        begin
                            if (!le[gi])
                            begin
                                if (prev_le)
                                begin
                                    val_reg[gi] <= value;
                                    pri_reg[gi] <= priority_req;
                                end
                                else
                                begin
                                    val_reg[gi] <= up_val;
                                    pri_reg[gi] <= up_pri;
                                end
                            end
                        end
                        spd_pkg::OP_PUSH_FRONT:
                        begin
                            if (gi == 0)
                            begin
                                val_reg[gi] <= value;
                                pri_reg[gi] <= '0;
                            end
                            else
                            begin
                                val_reg[gi] <= up_val;
                                pri_reg[gi] <= up_pri;
                            end
                        end
                        spd_pkg::OP_POP_FRONT:
                        begin
                            val_reg[gi] <= dn_val;
                            pri_reg[gi] <= dn_pri;
                        end
                        default:
                        begin
                            val_reg[gi] <= val_reg[gi];
                        end
                    endcase
                end
            end
        end
    endgenerate

    assign value_res = value_res_reg;
    assign status    = status_reg;
    assign count     = spd_pkg::COUNT_W'(occ_reg);

endmodule

>>> rtl/spd_controller.sv
`timescale 1ns / 1ps
// ============================================================================
// Sorted priority deque controller
// Decodes requests against the store status and tracks the result register.
// ============================================================================
module spd_controller
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  logic [1:0]     func,
    output logic           res_valid,
    input  logic           res_stall,
    input  spd_pkg::stat_t stat,
    output spd_pkg::cmd_t  cmd
);

    typedef enum logic {
        S_IDLE,
        S_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // A new transaction enters whenever the result register is free or is
    // being drained in this cycle.
    assign req_stall = (state_reg == S_HOLD) && res_stall;
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        cmd.exec = accept;
        unique case (spd_pkg::func_t'(func))
            spd_pkg::FUNC_INSERT:
                cmd.op = stat.full ? spd_pkg::OP_REJECT_FULL : spd_pkg::OP_INSERT;
            spd_pkg::FUNC_PUSH_FRONT:
                cmd.op = stat.full ? spd_pkg::OP_REJECT_FULL : spd_pkg::OP_PUSH_FRONT;
            spd_pkg::FUNC_POP_FRONT:
                cmd.op = stat.empty ? spd_pkg::OP_REJECT_EMPTY : spd_pkg::OP_POP_FRONT;
            spd_pkg::FUNC_POP_REAR:
                cmd.op = stat.empty ? spd_pkg::OP_REJECT_EMPTY : spd_pkg::OP_POP_REAR;
            default:
                cmd.op = spd_pkg::OP_REJECT_EMPTY;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (!res_stall && !accept)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign res_valid = (state_reg == S_HOLD);

endmodule

>>> rtl/sorted_priority_deque.sv
`timescale 1ns / 1ps
// ============================================================================
// Sorted priority deque
// Bounded store of value/priority entries kept in ascending priority order.
// ============================================================================
// Usage:
// A request transaction carries func, value and priority_req on the request
// channel (req_valid, req_stall); it is taken at a clock edge where req_valid
// is high and req_stall is low. Every request yields exactly one result
// transaction on the result channel (res_valid, res_stall) carrying
// value_res, status and count.
// The result appears in the cycle after the request is taken. Throughput is
// one transaction per cycle while no result waits under res_stall, set by the
// update of the cell row, where every cell compares its own priority with the
// request in parallel and shifts by at most one place.
// While a result waits under res_stall, req_stall is raised and no new
// request enters; once the result is taken a request may enter in the same
// cycle. Reset clears the occupancy and the result valid flag; cell contents
// are not cleared, as only cells below the occupancy are ever read.
// A pop on an empty store returns 0 with status empty; an insert or push
// front on a full store is dropped with status full.
// ============================================================================
module sorted_priority_deque
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic        [1:0]                   func,
    input  logic signed [spd_pkg::VALUE_W-1:0]  value,
    input  logic        [spd_pkg::PRI_W-1:0]    priority_req,
    output logic                                res_valid,
    input  logic                                res_stall,
    output logic signed [spd_pkg::VALUE_W-1:0]  value_res,
    output logic        [1:0]                   status,
    output logic        [spd_pkg::COUNT_W-1:0]  count
);

    spd_pkg::cmd_t  cmd;
    spd_pkg::stat_t stat;

    // The controller decides the operation from func and the store status.
    spd_controller u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .func      (func),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds the sorted cells and the result register.
    spd_datapath u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .value        (value),
        .priority_req (priority_req),
        .stat         (stat),
        .value_res    (value_res),
        .status       (status),
        .count        (count)
    );

endmodule

>>> rtl/spd_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// Sorted priority deque checker
// Port-level checks on the request and result channels, bound to the top level.
// ============================================================================
module spd_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                req_valid,
    input logic                                req_stall,
    input logic                                res_valid,
    input logic                                res_stall,
    input logic signed [spd_pkg::VALUE_W-1:0]  value_res,
    input logic        [1:0]                   status,
    input logic        [spd_pkg::COUNT_W-1:0]  count
);

    // An empty pop leaves nothing in the store and returns a zero word.
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && status == spd_pkg::STATUS_EMPTY) |-> (count == '0 && value_res == '0))
        else $error("empty result with nonzero count or value");

    // A rejected insert or push front only happens with the store at capacity.
    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && status == spd_pkg::STATUS_FULL)
        |-> (count == spd_pkg::COUNT_W'(spd_pkg::CAPACITY) && value_res == '0))
        else $error("full result below capacity");

    // Status is never the unused code.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (status != 2'd3))
        else $error("invalid status code");

    // A stalled result holds its word.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(value_res)))
        else $error("stalled result changed");

    // The request side is held off only while a result waits under a stall,
    // and every accepted request shows its result in the next cycle.
    a_req_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (req_stall |-> (res_valid && res_stall)) and
        ((req_valid && !req_stall) |=> res_valid))
        else $error("request flow broken");

endmodule

bind sorted_priority_deque spd_checker u_spd_checker (.*);

>>> test/spd_order_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// Sorted priority deque order checker
// Watches both channels, keeps its own sorted copy of the store and compares
// every result transaction with the outcome predicted for its request.
// ============================================================================
module spd_order_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    input  logic                                req_stall,
    input  logic        [1:0]                   func,
    input  logic signed [spd_pkg::VALUE_W-1:0]  value,
    input  logic        [spd_pkg::PRI_W-1:0]    priority_req,
    input  logic                                res_valid,
    input  logic                                res_stall,
    input  logic signed [spd_pkg::VALUE_W-1:0]  value_res,
    input  logic        [1:0]                   status,
    input  logic        [spd_pkg::COUNT_W-1:0]  count,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  results_seen,
    output int                                  full_seen,
    output int                                  empty_seen
);

    typedef struct {
        logic signed [spd_pkg::VALUE_W-1:0] value_res;
        spd_pkg::status_t                   status;
        logic        [spd_pkg::COUNT_W-1:0] count;
    } deque_result_t;

    deque_result_t                      expected_results[$];
    logic signed [spd_pkg::VALUE_W-1:0] stored_value[spd_pkg::CAPACITY];
    logic        [spd_pkg::PRI_W-1:0]   stored_pri[spd_pkg::CAPACITY];
    int                                 held;

    initial
    begin
        fail_count   = 0;
        pending      = 0;
        results_seen = 0;
        full_seen    = 0;
        empty_seen   = 0;
        held         = 0;
    end

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // Applies one request to the shadow store and queues the result it must give.
    task automatic predict_outcome(input spd_pkg::func_t op,
                                   input logic signed [spd_pkg::VALUE_W-1:0] word,
                                   input logic [spd_pkg::PRI_W-1:0] pri);
        deque_result_t outcome;
        int            pos;
        int            i;
        outcome.value_res = '0;
        outcome.status    = spd_pkg::STATUS_OK;
        case (op)
            spd_pkg::FUNC_INSERT, spd_pkg::FUNC_PUSH_FRONT:
            begin
                if (held >= spd_pkg::CAPACITY)
                begin
                    outcome.status = spd_pkg::STATUS_FULL;
                end
                else
                begin
                    // An insert goes behind every entry of lower or equal priority.
                    pos = 0;
                    if (op == spd_pkg::FUNC_INSERT)
                    begin
                        while (pos < held && stored_pri[pos] <= pri)
                        begin
                            pos++;
                        end
                    end
                    for (i = held; i > pos; i--)
                    begin
                        stored_value[i] = stored_value[i - 1];
                        stored_pri[i]   = stored_pri[i - 1];
                    end
                    stored_value[pos] = word;
                    stored_pri[pos]   = (op == spd_pkg::FUNC_INSERT) ? pri : '0;
                    held++;
                end
            end
            default:
            begin
                if (held == 0)
                begin
                    outcome.status = spd_pkg::STATUS_EMPTY;
                end
                else if (op == spd_pkg::FUNC_POP_FRONT)
                begin
                    outcome.value_res = stored_value[0];
                    for (i = 1; i < held; i++)
                    begin
                        stored_value[i - 1] = stored_value[i];
                        stored_pri[i - 1]   = stored_pri[i];
                    end
                    held--;
                end
                else
                begin
                    outcome.value_res = stored_value[held - 1];
                    held--;
                end
            end
        endcase
        outcome.count = spd_pkg::COUNT_W'(held);
        expected_results.push_back(outcome);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        deque_result_t oldest;
        if (!rst_n)
        begin
            held = 0;
            expected_results.delete();
            pending = 0;
        end
        else
        begin
            // A result can never belong to the request taken at the same edge,
            // so results are checked before the new request is predicted.
            if (res_valid && !res_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    note_failure($sformatf("unexpected result value_res=%0d status=%0d count=%0d",
                                           value_res, status, count));
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (oldest.status == spd_pkg::STATUS_FULL)
                    begin
                        full_seen++;
                    end
                    if (oldest.status == spd_pkg::STATUS_EMPTY)
                    begin
                        empty_seen++;
                    end
                    if (value_res !== oldest.value_res)
                    begin
                        note_failure($sformatf("value_res expected %0d, got %0d",
                                               oldest.value_res, value_res));
                    end
                    if (status !== oldest.status)
                    begin
                        note_failure($sformatf("status expected %0d, got %0d",
                                               oldest.status, status));
                    end
                    if (count !== oldest.count)
                    begin
                        note_failure($sformatf("count expected %0d, got %0d",
                                               oldest.count, count));
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                predict_outcome(spd_pkg::func_t'(func), value, priority_req);
            end
            pending = expected_results.size();
        end
    end

endmodule

>>> test/sorted_priority_deque_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Sorted priority deque testbench
// Drives directed and random request transactions with random gaps and
// result stalls; a separate order checker predicts and compares every result.
// ============================================================================
module sorted_priority_deque_tb;

    localparam int RANDOM_OPS  = 1400;
    localparam int PHASE_LEN   = 60;
    localparam int QUIET_FIRST = 700;
    localparam int QUIET_LAST  = 1100;
    localparam int DRAIN_LIMIT = 1000;

    logic                               clk          = 1'b0;
    logic                               rst_n        = 1'b0;
    logic                               req_valid    = 1'b0;
    logic                               req_stall;
    logic        [1:0]                  func         = spd_pkg::FUNC_INSERT;
    logic signed [spd_pkg::VALUE_W-1:0] value        = '0;
    logic        [spd_pkg::PRI_W-1:0]   priority_req = '0;
    logic                               res_valid;
    logic                               res_stall    = 1'b0;
    logic signed [spd_pkg::VALUE_W-1:0] value_res;
    logic        [1:0]                  status;
    logic        [spd_pkg::COUNT_W-1:0] count;

    int   fail_count;
    int   pending;
    int   results_seen;
    int   full_seen;
    int   empty_seen;
    int   cycle_count = 0;
    logic quiet;
    logic drain_timeout = 1'b0;

    // 10 ns clock: high for half the period, low for the other half.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // During this window of cycles neither side idles, so the deque sees a
    // stretch of back-to-back transactions at full rate.
    assign quiet = (cycle_count >= QUIET_FIRST) && (cycle_count < QUIET_LAST);

    sorted_priority_deque i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .func         (func),
        .value        (value),
        .priority_req (priority_req),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .value_res    (value_res),
        .status       (status),
        .count        (count)
    );

    spd_order_checker i_order_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .func         (func),
        .value        (value),
        .priority_req (priority_req),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .value_res    (value_res),
        .status       (status),
        .count        (count),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .full_seen    (full_seen),
        .empty_seen   (empty_seen)
    );

    // The result side stalls at random with a chance of six percent. The stall is
    // changed only at the falling edge so it is stable at every rising edge.
    always @(negedge clk)
    begin
        res_stall <= !quiet && ($urandom_range(99) < 6);
    end

    // Offers one request transaction and returns at the falling edge after it
    // has been taken. An optional gap comes first; once valid is raised the
    // payload holds until the deque accepts it. The caller is always at a
    // falling edge, so each call changes valid at most once per time step.
    task automatic send_request(input spd_pkg::func_t op,
                                input logic signed [spd_pkg::VALUE_W-1:0] word,
                                input logic [spd_pkg::PRI_W-1:0] pri);
        logic taken;
        taken = 1'b0;
        while (!quiet && $urandom_range(99) < 6)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid    <= 1'b1;
        func         <= op;
        value        <= word;
        priority_req <= pri;
        while (!taken)
        begin
            @(posedge clk);
            taken = !req_stall;
            @(negedge clk);
        end
    endtask

    initial
    begin
        spd_pkg::func_t                     op;
        logic signed [spd_pkg::VALUE_W-1:0] word;
        logic        [spd_pkg::PRI_W-1:0]   pri;
        int                                 roll;
        int                                 insert_pct;
        int                                 guard;

        // Reset is held from the start and released at a falling edge.
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Pops on the empty store, from both ends.
        send_request(spd_pkg::FUNC_POP_FRONT, 32'sd0, 8'd0);
        send_request(spd_pkg::FUNC_POP_REAR, 32'sd0, 8'd0);

        // Extremes of value and priority. The push front lands ahead of the
        // existing priority 0 entry, and the later priority 0 insert goes
        // behind both of them but ahead of priority 255.
        send_request(spd_pkg::FUNC_INSERT, 32'sh7FFF_FFFF, 8'd255);
        send_request(spd_pkg::FUNC_INSERT, 32'sh8000_0000, 8'd0);
        send_request(spd_pkg::FUNC_PUSH_FRONT, -32'sd1, 8'd255);
        send_request(spd_pkg::FUNC_INSERT, 32'sd0, 8'd0);
        send_request(spd_pkg::FUNC_INSERT, 32'sd1234, 8'd128);
        send_request(spd_pkg::FUNC_INSERT, 32'sd5678, 8'd128);

        // Fill the store to capacity, then knock on it with both insert forms.
        for (int i = 0; i < spd_pkg::CAPACITY - 6; i++)
        begin
            send_request(spd_pkg::FUNC_INSERT, $signed($urandom), 8'(i * 23));
        end
        send_request(spd_pkg::FUNC_INSERT, 32'sd99, 8'd1);
        send_request(spd_pkg::FUNC_PUSH_FRONT, 32'sd98, 8'd0);

        // Take entries off both ends of the full store, then push one back.
        send_request(spd_pkg::FUNC_POP_FRONT, 32'sd0, 8'd0);
        send_request(spd_pkg::FUNC_POP_REAR, 32'sd0, 8'd0);
        send_request(spd_pkg::FUNC_POP_FRONT, 32'sd0, 8'd0);
        send_request(spd_pkg::FUNC_PUSH_FRONT, 32'sh5A5A_A5A5, 8'd17);

        // Random part. Phases rotate between filling, draining and a balanced
        // mix so that the store keeps swinging between empty and full.
        for (int k = 0; k < RANDOM_OPS; k++)
        begin
            case ((k / PHASE_LEN) % 3)
                0:       insert_pct = 75;
                1:       insert_pct = 25;
                default: insert_pct = 50;
            endcase

            roll = $urandom_range(99);
            if (roll < insert_pct)
            begin
                op = ($urandom_range(99) < 80) ? spd_pkg::FUNC_INSERT
                                               : spd_pkg::FUNC_PUSH_FRONT;
            end
            else
            begin
                op = $urandom_range(1) ? spd_pkg::FUNC_POP_FRONT : spd_pkg::FUNC_POP_REAR;
            end

            // Half the time a narrow band of priorities so that ties are common.
            roll = $urandom_range(99);
            if (roll < 50)
            begin
                pri = 8'($urandom_range(7));
            end
            else if (roll < 90)
            begin
                pri = 8'($urandom_range(255));
            end
            else
            begin
                pri = $urandom_range(1) ? 8'd255 : 8'd0;
            end

            roll = $urandom_range(99);
            if (roll < 90)
            begin
                word = $signed($urandom);
            end
            else
            begin
                case ($urandom_range(3))
                    0:       word = 32'sh7FFF_FFFF;
                    1:       word = 32'sh8000_0000;
                    2:       word = -32'sd1;
                    default: word = 32'sd0;
                endcase
            end

            send_request(op, word, pri);
        end
        req_valid <= 1'b0;

        // Wait for every outstanding result, then keep running so that a stray
        // extra result would still be caught.
        guard = 0;
        while (pending != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (pending != 0)
        begin
            drain_timeout = 1'b1;
            $display("%0d results still outstanding at the end of the run", pending);
        end
        repeat (4) @(posedge clk);

        $display("Checked %0d result transactions in %0d cycles.", results_seen, cycle_count);
        $display("Of these, %0d were pops on an empty store and %0d were refused as full.",
                 empty_seen, full_seen);
        if (fail_count == 0 && !drain_timeout)
        begin
            $display("** sorted_priority_deque: PASSED **");
        end
        else
        begin
            $display("** sorted_priority_deque: FAILED **");
        end
        $finish;
    end

    // Watchdog: 2 ms is far beyond any correct run.
    initial
    begin
        #2000000;
        $display("Run did not finish in time.");
        $display("** sorted_priority_deque: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
rtl/spd_pkg.sv
rtl/spd_datapath.sv
rtl/spd_controller.sv
rtl/sorted_priority_deque.sv
rtl/spd_checker.sv
test/spd_order_checker.sv
test/sorted_priority_deque_tb.sv
